// File: sv/ptts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Types and constants shared by the periodic task tick scheduler modules.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int NRES_W = 4;

  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_CREATE  = 3'd1;
  localparam logic [2:0] MODE_DELETE  = 3'd2;
  localparam logic [2:0] MODE_SUSPEND = 3'd3;
  localparam logic [2:0] MODE_RESUME  = 3'd4;
  localparam logic [2:0] MODE_QUERY   = 3'd5;

  localparam logic [2:0] STATUS_FIRED      = 3'd0;
  localparam logic [2:0] STATUS_FIRED_NONE = 3'd1;
  localparam logic [2:0] STATUS_DONE       = 3'd2;
  localparam logic [2:0] STATUS_FULL       = 3'd3;
  localparam logic [2:0] STATUS_NOT_FOUND  = 3'd4;

  localparam logic [1:0] TASK_READY     = 2'd0;
  localparam logic [1:0] TASK_SUSPENDED = 2'd1;
  localparam logic [1:0] TASK_DELETED   = 2'd2;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_READ,
    SEQ_PROC,
    SEQ_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [1:0]  slot_state;
    logic [15:0] countdown;
    logic [15:0] period;
  } slot_t;

  typedef struct packed {
    logic       push;
    logic [2:0] status;
    logic [7:0] id;
    logic [1:0] task_state;
    logic       last;
  } result_t;

endpackage

// File: sv/ptts_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_slot_ram
// Task slot table: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module ptts_slot_ram #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  ptts_pkg::slot_t      wdata,
  input  logic                 re,
  input  logic [IDX_W-1:0]     raddr,
  output ptts_pkg::slot_t      rdata
);

  ptts_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/ptts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_ctrl
// Sequencer that walks the used slots one at a time for each tick and for
// every command but create, and produces the result transactions.
// ----------------------------------------------------------------------------
module ptts_ctrl #(
  parameter int MAX_TASKS = 8,
  parameter int IDX_W = 3,
  parameter int CNT_W = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           mode,
  input  logic [7:0]           task_id,
  input  logic [15:0]          period,
  input  logic [15:0]          initial_delay,
  input  logic                 out_free,
  output ptts_pkg::result_t    res_push,
  output logic                 ram_we,
  output logic [IDX_W-1:0]     ram_waddr,
  output ptts_pkg::slot_t      ram_wdata,
  output logic                 ram_re,
  output logic [IDX_W-1:0]     ram_raddr,
  input  ptts_pkg::slot_t      ram_rdata
);

  ptts_pkg::seq_state_t state, state_next;
  logic [2:0]                  mode_r, mode_r_next;
  logic [7:0]                  id_r, id_r_next;
  logic [IDX_W-1:0]            idx, idx_next;
  logic [CNT_W-1:0]            count, count_next;
  logic [ptts_pkg::NRES_W-1:0] nres, nres_next;
  logic [2:0]                  res_status, res_status_next;
  logic [7:0]                  res_id, res_id_next;
  logic [1:0]                  res_tstate, res_tstate_next;

  logic match;
  logic last_slot;
  logic hold;

  assign in_stall  = (state != ptts_pkg::SEQ_IDLE);
  assign match     = (ram_rdata.task_id == id_r);
  assign last_slot = ((CNT_W'(idx) + CNT_W'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptts_pkg::SEQ_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_r_next;
    id_r       <= id_r_next;
    idx        <= idx_next;
    nres       <= nres_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
    res_tstate <= res_tstate_next;
  end

  always_comb begin
    state_next      = state;
    mode_r_next     = mode_r;
    id_r_next       = id_r;
    idx_next        = idx;
    count_next      = count;
    nres_next       = nres;
    res_status_next = res_status;
    res_id_next     = res_id;
    res_tstate_next = res_tstate;
    res_push        = '0;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = ram_rdata;
    ram_re          = 1'b0;
    ram_raddr       = idx;
    hold            = 1'b0;

    case (state)
      ptts_pkg::SEQ_IDLE: begin
        if (in_valid) begin
          case (mode)
            ptts_pkg::MODE_CREATE: begin
              res_id_next     = task_id;
              res_tstate_next = ptts_pkg::TASK_READY;
              if (count < CNT_W'(MAX_TASKS)) begin
                ram_we               = 1'b1;
                ram_waddr            = count[IDX_W-1:0];
                ram_wdata.task_id    = task_id;
                ram_wdata.slot_state = ptts_pkg::TASK_READY;
                ram_wdata.countdown  = initial_delay;
                ram_wdata.period     = period;
                count_next           = count + CNT_W'(1);
                res_status_next      = ptts_pkg::STATUS_DONE;
              end else begin
                res_status_next = ptts_pkg::STATUS_FULL;
              end
              state_next = ptts_pkg::SEQ_EMIT;
            end
            ptts_pkg::MODE_TICK, ptts_pkg::MODE_DELETE, ptts_pkg::MODE_SUSPEND,
            ptts_pkg::MODE_RESUME, ptts_pkg::MODE_QUERY: begin
              mode_r_next     = mode;
              id_r_next       = task_id;
              idx_next        = '0;
              nres_next       = '0;
              res_tstate_next = ptts_pkg::TASK_READY;
              res_id_next     = task_id;
              if (mode == ptts_pkg::MODE_TICK) begin
                res_status_next = ptts_pkg::STATUS_FIRED_NONE;
                res_id_next     = '0;
              end else if (mode == ptts_pkg::MODE_QUERY) begin
                res_status_next = ptts_pkg::STATUS_NOT_FOUND;
              end else begin
                res_status_next = ptts_pkg::STATUS_DONE;
              end
              state_next = (count == '0) ? ptts_pkg::SEQ_EMIT : ptts_pkg::SEQ_READ;
            end
            default: begin
              state_next = ptts_pkg::SEQ_IDLE;
            end
          endcase
        end
      end

      ptts_pkg::SEQ_READ: begin
        ram_re     = 1'b1;
        state_next = ptts_pkg::SEQ_PROC;
      end

      ptts_pkg::SEQ_PROC: begin
        case (mode_r)
          ptts_pkg::MODE_TICK: begin
            if (ram_rdata.slot_state == ptts_pkg::TASK_READY) begin
              if (ram_rdata.countdown == 16'd0) begin
                if (nres < ptts_pkg::NRES_W'(ptts_pkg::MAX_RESULTS)) begin
                  if (nres != '0) begin
                    if (out_free) begin
                      res_push.push       = 1'b1;
                      res_push.status     = res_status;
                      res_push.id         = res_id;
                      res_push.task_state = res_tstate;
                      res_push.last       = 1'b0;
                    end else begin
                      hold = 1'b1;
                    end
                  end
                  if (!hold) begin
                    res_status_next = ptts_pkg::STATUS_FIRED;
                    res_id_next     = ram_rdata.task_id;
                    res_tstate_next = ptts_pkg::TASK_READY;
                    nres_next       = nres + ptts_pkg::NRES_W'(1);
                  end
                end
                ram_wdata.countdown = ram_rdata.period - 16'd1;
              end else begin
                ram_wdata.countdown = ram_rdata.countdown - 16'd1;
              end
              ram_we = !hold;
            end
          end
          ptts_pkg::MODE_DELETE: begin
            ram_wdata.slot_state = ptts_pkg::TASK_DELETED;
            ram_we               = match;
          end
          ptts_pkg::MODE_SUSPEND: begin
            ram_wdata.slot_state = ptts_pkg::TASK_SUSPENDED;
            ram_we               = match;
          end
          ptts_pkg::MODE_RESUME: begin
            ram_wdata.slot_state = ptts_pkg::TASK_READY;
            ram_we               = match;
          end
          ptts_pkg::MODE_QUERY: begin
            if (match) begin
              res_status_next = ptts_pkg::STATUS_DONE;
              res_tstate_next = ram_rdata.slot_state;
            end
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase

        if (!hold) begin
          if (last_slot || (mode_r == ptts_pkg::MODE_QUERY && match)) begin
            state_next = ptts_pkg::SEQ_EMIT;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = ptts_pkg::SEQ_READ;
          end
        end
      end

      ptts_pkg::SEQ_EMIT: begin
        if (out_free) begin
          res_push.push       = 1'b1;
          res_push.status     = res_status;
          res_push.id         = res_id;
          res_push.task_state = res_tstate;
          res_push.last       = 1'b1;
          state_next          = ptts_pkg::SEQ_IDLE;
        end
      end

      default: begin
        state_next = ptts_pkg::SEQ_IDLE;
      end
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TASKS))
    else $error("used slot count beyond table size");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ptts_pkg::SEQ_IDLE || state == ptts_pkg::SEQ_PROC))
    else $error("slot write outside idle or processing state");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    res_push.push |-> out_free)
    else $error("result pushed into a full output register");

  a_mid_push_not_last: assert property (@(posedge clk) disable iff (rst)
    (res_push.push && state == ptts_pkg::SEQ_PROC) |->
      (!res_push.last && mode_r == ptts_pkg::MODE_TICK))
    else $error("intermediate result marked last or outside a tick");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (res_push.push && res_push.last) |=> (state == ptts_pkg::SEQ_IDLE))
    else $error("sequencer not idle after final result");

endmodule

// File: sv/periodic_task_tick_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top
// Table of periodic tasks driven by tick and command transactions.
// ----------------------------------------------------------------------------
// Usage: an input transaction (mode, task_id, period, initial_delay) is taken
// when in_valid is high and in_stall is low. Every tick or command answers
// with one or more output transactions (status, fired_or_queried_id,
// task_state, last); last marks the final one. Modes six and seven are
// taken and dropped without an answer.
// Timing: create goes straight to the emit state and loads its answer into
// the output register. Tick, delete, suspend, resume and query walk the
// used slots through the slot table, each slot in a read step and then an
// update step; a query stops at its first match. in_stall stays high until
// the final answer is loaded into the output register.
// Reset clears the sequencer state, the used slot count and the output valid
// flag; the table itself needs no clearing since only created slots are read.
// When the receiver holds out_stall, the walk pauses at the next firing slot
// and the current output transaction holds steady until taken.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_top #(
  parameter int MAX_TASKS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [7:0]  task_id,
  input  logic [15:0] period,
  input  logic [15:0] initial_delay,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  fired_or_queried_id,
  output logic [1:0]  task_state,
  output logic        last
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  ptts_pkg::result_t res_push;
  ptts_pkg::slot_t   ram_wdata;
  ptts_pkg::slot_t   ram_rdata;
  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  logic              out_free;
  logic              out_valid_next;

  assign out_free = !out_valid || !out_stall;

  ptts_ctrl #(
    .MAX_TASKS (MAX_TASKS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .task_id       (task_id),
    .period        (period),
    .initial_delay (initial_delay),
    .out_free      (out_free),
    .res_push      (res_push),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  ptts_slot_ram #(
    .DEPTH (MAX_TASKS),
    .IDX_W (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_valid_next = out_valid;
    if (res_push.push) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push.push) begin
      status              <= res_push.status;
      fired_or_queried_id <= res_push.id;
      task_state          <= res_push.task_state;
      last                <= res_push.last;
    end
  end

endmodule
